// File: hw/rtl/perfect_power_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Perfect power classifier assertion macros
// Shared property forms; they expect clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef PERFECT_POWER_CLASSIFIER_TOP_ASSERT_SVH
`define PERFECT_POWER_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Perfect power classifier package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_CHECK,
        ST_FINISH
    } ppc_state_t;

    typedef struct packed {
        logic load;
        logic probe;
        logic mul_lo;
        logic mul_hi;
        logic accum;
        logic check;
        logic publish;
    } ppc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic last_bit;
        logic last_exp;
    } ppc_sts_t;

endpackage

// File: hw/rtl/perfect_power_classifier_top.sv
// ----------------------------------------------------------------------------
// Perfect power classifier
// Takes one signed integer per request and reports, for exponents 2, 3, 4
// and 5, whether it is an exact power of some integer base; zero and negative
// values match nothing and one matches all four. Each exponent is tested by
// a bitwise search for the integer root, one root bit per probe, raising the
// candidate to the exponent on a single shared multiplier that forms each
// product from two half-width partial products. Each probe forms the power of
// its candidate with repeated multiplies, stopping early once the power
// overflows, and exponent e needs ceil((VALUE_BITS-1)/e) probes. One item is
// worked on at a time; a finished result waits in an output register while
// the next request is accepted.
// ----------------------------------------------------------------------------
module perfect_power_classifier_top #(
    parameter int VALUE_BITS = ppc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits from the lowest up: value, zero fill to whole bytes.
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Bits from the lowest up: is_square, is_cube, is_fourth_power,
    // is_fifth_power, four zero bits.
    output logic [7:0]                          m_axis_tdata
);
    import ppc_pkg::*;

    ppc_cmd_t   cmd;
    ppc_sts_t   sts;
    logic [3:0] result;

    ppc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (s_axis_tdata[VALUE_BITS-1:0]),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    assign m_axis_tdata = {4'b0000, result};

endmodule

// File: hw/rtl/ppc_datapath.sv
// ----------------------------------------------------------------------------
// Perfect power classifier datapath
// Bitwise root search per exponent on one shared multiplier, result register.
// ----------------------------------------------------------------------------
module ppc_datapath #(
    parameter int VALUE_BITS = ppc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_BITS-1:0]  value,
    input  ppc_pkg::ppc_cmd_t      cmd,
    output ppc_pkg::ppc_sts_t      sts,
    output logic [3:0]             result
);
    import ppc_pkg::*;

    localparam int RB = VALUE_BITS / 2;
    localparam int MW = VALUE_BITS - 1;
    localparam int SW = 3 * RB;
    localparam int IW = $clog2(RB);
    localparam int S2 = (VALUE_BITS + 0) / 2 - 1;
    localparam int S3 = (VALUE_BITS + 1) / 3 - 1;
    localparam int S4 = (VALUE_BITS + 2) / 4 - 1;
    localparam int S5 = (VALUE_BITS + 3) / 5 - 1;
    localparam logic [1:0] EXP_SEL_FIRST = 2'd0;
    localparam logic [1:0] EXP_SEL_LAST  = 2'd3;

    function automatic logic [IW-1:0] start_of(input logic [1:0] sel);
        logic [IW-1:0] s;
        case (sel)
            2'd0:    s = IW'(S2);
            2'd1:    s = IW'(S3);
            2'd2:    s = IW'(S4);
            default: s = IW'(S5);
        endcase
        return s;
    endfunction

    logic [MW-1:0]   mag_reg;
    logic [RB-1:0]   root_reg;
    logic [RB-1:0]   cand_reg;
    logic [IW-1:0]   bit_idx_reg;
    logic [1:0]      exp_sel_reg;
    logic [MW-1:0]   acc_reg;
    logic            ovf_reg;
    logic [2:0]      mul_left_reg;
    logic [2*RB-1:0] prod_lo_reg;
    logic [2*RB-1:0] prod_hi_reg;
    logic [3:0]      match_reg;
    logic [3:0]      res_reg;

    logic [RB-1:0]   cand;
    logic [RB-1:0]   mul_a;
    logic [2*RB-1:0] mul_p;
    logic [SW-1:0]   sum;
    logic            le;
    logic            eq;

    assign cand  = root_reg | (RB'(1) << bit_idx_reg);
    assign mul_a = cmd.mul_hi ? RB'(acc_reg >> RB) : acc_reg[RB-1:0];
    assign mul_p = mul_a * cand_reg;
    assign sum   = (SW'(prod_hi_reg) << RB) + SW'(prod_lo_reg);
    assign le    = !ovf_reg && (acc_reg <= mag_reg);
    assign eq    = !ovf_reg && (acc_reg == mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg      <= '0;
            root_reg     <= '0;
            cand_reg     <= '0;
            acc_reg      <= '0;
            prod_lo_reg  <= '0;
            prod_hi_reg  <= '0;
            exp_sel_reg  <= EXP_SEL_FIRST;
            bit_idx_reg  <= '0;
            mul_left_reg <= '0;
            ovf_reg      <= 1'b0;
            match_reg    <= '0;
            res_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                mag_reg     <= value[VALUE_BITS-1] ? '0 : value[MW-1:0];
                root_reg    <= '0;
                exp_sel_reg <= EXP_SEL_FIRST;
                bit_idx_reg <= start_of(EXP_SEL_FIRST);
                match_reg   <= '0;
            end
            if (cmd.probe)
            begin
                cand_reg     <= cand;
                acc_reg      <= MW'(cand);
                ovf_reg      <= 1'b0;
                mul_left_reg <= 3'({1'b0, exp_sel_reg}) + 3'd1;
            end
            if (cmd.mul_lo)
            begin
                prod_lo_reg <= mul_p;
            end
            if (cmd.mul_hi)
            begin
                prod_hi_reg <= mul_p;
            end
            if (cmd.accum)
            begin
                acc_reg      <= sum[MW-1:0];
                ovf_reg      <= |sum[SW-1:MW];
                mul_left_reg <= mul_left_reg - 3'd1;
            end
            if (cmd.check)
            begin
                if (eq)
                begin
                    match_reg[exp_sel_reg] <= 1'b1;
                end
                if (bit_idx_reg == '0)
                begin
                    root_reg    <= '0;
                    exp_sel_reg <= exp_sel_reg + 2'd1;
                    bit_idx_reg <= start_of(exp_sel_reg + 2'd1);
                end
                else
                begin
                    if (le)
                    begin
                        root_reg <= cand_reg;
                    end
                    bit_idx_reg <= bit_idx_reg - IW'(1);
                end
            end
            if (cmd.publish)
            begin
                res_reg <= match_reg;
            end
        end
    end

    assign sts.mul_done = (mul_left_reg == 3'd0) || ovf_reg;
    assign sts.last_bit = (bit_idx_reg == '0);
    assign sts.last_exp = (exp_sel_reg == EXP_SEL_LAST);
    assign result       = res_reg;

endmodule

// File: hw/rtl/ppc_controller.sv
// ----------------------------------------------------------------------------
// Perfect power classifier controller
// Sequences probes and multiplies, and owns both request handshakes.
// ----------------------------------------------------------------------------
`include "perfect_power_classifier_top_assert.svh"

module ppc_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ppc_pkg::ppc_sts_t sts,
    output ppc_pkg::ppc_cmd_t cmd
);
    import ppc_pkg::*;

    ppc_state_t state_reg;
    ppc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = (sts.last_bit && sts.last_exp) ? ST_FINISH : ST_PROBE;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `PPC_ASSERT_IMP(a_publish_slot_free, cmd.publish, !out_valid_reg || out_ready,
        "result published over an untaken result")
    `PPC_ASSERT_NXT(a_accept_starts_probe, in_valid && in_ready, state_reg == ST_PROBE,
        "accepted request did not start a probe")
    `PPC_ASSERT_NXT(a_mul_lo_then_hi, cmd.mul_lo, state_reg == ST_MUL_HI,
        "low partial product not followed by high partial product")
    `PPC_ASSERT_NXT(a_last_check_finishes, cmd.check && sts.last_bit && sts.last_exp,
        state_reg == ST_FINISH, "search did not finish after the last probe")

endmodule

// File: tb/sv/perfect_power_classifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perfect power classifier testbench
// Streams signed values into the classifier: a directed set of edge values,
// exact powers and near misses, then random values weighted toward exact
// powers. Each result is compared against flags computed by a saturating
// integer root search, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module perfect_power_classifier_top_tb;

    localparam int WORD_BITS  = ppc_pkg::VALUE_BITS_DEFAULT;
    localparam int DRAIN_WAIT = 400;
    localparam int HOLD_LEN   = 3000;

    typedef struct packed {
        bit is_fifth_power;
        bit is_fourth_power;
        bit is_cube;
        bit is_square;
    } power_flags_t;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        power_flags_t         flags;
    } flag_check_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_BITS-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    logic [WORD_BITS-1:0] value_backlog[$];
    flag_check_t          flag_checks[$];
    logic                 in_accepted = 1'b0;
    logic                 hold_active = 1'b0;
    int                   sender_idle_pct = 0;
    int                   receiver_stall_pct = 0;
    int                   failures = 0;
    int                   values_sent = 0;
    int                   results_checked = 0;
    int                   flag_tally[4] = '{0, 0, 0, 0};

    perfect_power_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned sat_product(longint unsigned a, longint unsigned b);
        if (a != 0 && b > (64'hFFFF_FFFF_FFFF_FFFF / a))
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return a * b;
    endfunction

    function automatic longint unsigned sat_power(longint unsigned base, int exponent);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < exponent; i++)
            acc = sat_product(acc, base);
        return acc;
    endfunction

    function automatic bit has_integer_root(longint unsigned mag, int exponent);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        lo = 1;
        hi = 64'h1_0000_0000;
        while (hi - lo > 1)
        begin
            mid = lo + ((hi - lo) >> 1);
            p = sat_power(mid, exponent);
            if (p == mag)
                return 1'b1;
            if (p > mag)
                hi = mid;
            else
                lo = mid;
        end
        return sat_power(lo, exponent) == mag;
    endfunction

    function automatic power_flags_t classify_value(logic [WORD_BITS-1:0] word);
        power_flags_t    flags;
        longint unsigned mag;
        flags = '0;
        mag = longint'(word);
        if (word[WORD_BITS-1] || word == 0)
            return flags;
        if (word == 1)
            return '1;
        flags.is_square       = has_integer_root(mag, 2);
        flags.is_cube         = has_integer_root(mag, 3);
        flags.is_fourth_power = has_integer_root(mag, 4);
        flags.is_fifth_power  = has_integer_root(mag, 5);
        return flags;
    endfunction

    function automatic logic [WORD_BITS-1:0] draw_value();
        int              pick;
        int              exponent;
        int              base;
        longint unsigned p;
        logic [WORD_BITS-1:0] word;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            exponent = $urandom_range(5, 2);
            case (exponent)
                2: base = $urandom_range(46340);
                3: base = $urandom_range(1290);
                4: base = $urandom_range(215);
                default: base = $urandom_range(73);
            endcase
            p = sat_power(longint'(base), exponent);
            word = p[WORD_BITS-1:0];
            case ($urandom_range(9))
                0: word = word + 1;
                1: word = word - 1;
                2: word = -word;
                default: ;
            endcase
        end
        else if (pick < 60)
            word = $urandom_range(300);
        else if (pick < 70)
            word = 32'd1 << $urandom_range(31);
        else
            word = $urandom();
        return word;
    endfunction

    task automatic report_failure(string msg);
        if (failures < 50)
            $display("ERROR @%0t: %s", $realtime, msg);
        failures++;
    endtask

    task automatic hold_receiver(int cycles);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_active = 1'b0;
    endtask

    task automatic drain_all();
        while (value_backlog.size() != 0 || s_axis_tvalid || flag_checks.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            value_backlog.push_back(draw_value());
    endtask

    always @(negedge clk)
    begin : request_driver
        logic                 next_valid;
        logic [WORD_BITS-1:0] next_data;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!s_axis_tvalid || in_accepted)
        begin
            next_valid = 1'b0;
            if (value_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_valid = 1'b1;
                next_data  = value_backlog.pop_front();
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        flag_check_t  want;
        power_flags_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[3:0];
                if (flag_checks.size() == 0)
                    report_failure($sformatf("result %b with no request pending", got));
                else
                begin
                    want = flag_checks.pop_front();
                    results_checked++;
                    if (got.is_square != want.flags.is_square)
                        report_failure($sformatf("value %0d: is_square %b, want %b",
                            $signed(want.word), got.is_square, want.flags.is_square));
                    if (got.is_cube != want.flags.is_cube)
                        report_failure($sformatf("value %0d: is_cube %b, want %b",
                            $signed(want.word), got.is_cube, want.flags.is_cube));
                    if (got.is_fourth_power != want.flags.is_fourth_power)
                        report_failure($sformatf("value %0d: is_fourth_power %b, want %b",
                            $signed(want.word), got.is_fourth_power,
                            want.flags.is_fourth_power));
                    if (got.is_fifth_power != want.flags.is_fifth_power)
                        report_failure($sformatf("value %0d: is_fifth_power %b, want %b",
                            $signed(want.word), got.is_fifth_power,
                            want.flags.is_fifth_power));
                end
            end
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                want.word  = s_axis_tdata;
                want.flags = classify_value(s_axis_tdata);
                flag_checks.push_back(want);
                values_sent++;
                flag_tally[0] += want.flags.is_square;
                flag_tally[1] += want.flags.is_cube;
                flag_tally[2] += want.flags.is_fourth_power;
                flag_tally[3] += want.flags.is_fifth_power;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int directed_count;
        logic [WORD_BITS-1:0] directed_values[];

        directed_values = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'd4, 32'd8, 32'd64, 32'd256,
            32'd1024, 32'd4096, 32'd1 << 20, 32'd1 << 30, 32'h7FFF_FFFF,
            32'h8000_0000, 32'd2147395600, 32'd2147395601, 32'd2146689000,
            32'd2136750625, 32'd2073071593, -32'sd8, -32'sd27, 32'h5555_5555,
            32'hAAAA_AAAA, 32'd3, 32'd65536
        };

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_count = directed_values.size();
        foreach (directed_values[i])
            value_backlog.push_back(directed_values[i]);
        drain_all();

        fork
            hold_receiver(HOLD_LEN);
        join_none
        queue_random(250);
        drain_all();

        sender_idle_pct = 85;
        queue_random(250);
        drain_all();

        sender_idle_pct = 0;
        receiver_stall_pct = 85;
        queue_random(250);
        drain_all();

        sender_idle_pct = 15;
        receiver_stall_pct = 15;
        queue_random(250);
        drain_all();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (flag_checks.size() != 0)
            report_failure("results still outstanding at end of run");

        $display("Classified %0d values (%0d directed) across four idling patterns and a long",
            values_sent, directed_count);
        $display("output stall; checked %0d results: %0d squares, %0d cubes, %0d fourth, %0d fifth",
            results_checked, flag_tally[0], flag_tally[1], flag_tally[2], flag_tally[3]);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_datapath.sv
hw/rtl/ppc_controller.sv
hw/rtl/perfect_power_classifier_top.sv
tb/sv/perfect_power_classifier_top_tb.sv
